// ----- hw/rtl/efr_pkg.sv -----
// Package for the Euler frame rotation block: widths, CORDIC constants, types.
// No dependencies.
package efr_pkg;
   localparam int AngW = 16;
   localparam int VecW = 32;
   localparam int QW = 34;          // Q30 sin/cos/matrix carrier, signed
   localparam int ZW = 34;
   localparam int CordicStagesDef = 16;
   localparam logic signed [ZW-1:0] Q30Pi = 34'sd3373259426;
   localparam logic signed [ZW-1:0] Q30HalfPi = 34'sd1686629713;
   localparam logic signed [QW-1:0] Q30Gain = 34'sd652032874;

   typedef logic signed [QW-1:0] q30_type;

   function automatic logic signed [ZW-1:0] atan_q30(input int i);
      logic signed [ZW-1:0] r;
      case (i)
         0: r = 34'sd843314857;
         1: r = 34'sd497837829;
         2: r = 34'sd263043837;
         3: r = 34'sd133525159;
         4: r = 34'sd67021688;
         5: r = 34'sd33543516;
         6: r = 34'sd16775851;
         7: r = 34'sd8388437;
         8: r = 34'sd4194283;
         9: r = 34'sd2097149;
         default: r = (i < 31) ? (ZW'(1) <<< (30 - i)) : '0;
      endcase
      return r;
   endfunction

   // Q30 product with rounding
   function automatic q30_type mul30(input q30_type a, input q30_type b);
      logic signed [2*QW-1:0] p;
      p = a * b + (68'sd1 <<< 29);
      return QW'(p >>> 30);
   endfunction
endpackage

// ----- hw/rtl/efr_cordic.sv -----
// Pipelined rotation-mode CORDIC: sine and cosine in Q30 of a Q2.13 angle.
// Depends on efr_pkg.
module efr_cordic #(
   parameter int Stages = efr_pkg::CordicStagesDef
) (
   input  logic                              clock,
   input  logic signed [efr_pkg::AngW-1:0]   angle,
   output efr_pkg::q30_type                  sin_q,
   output efr_pkg::q30_type                  cos_q
);
   import efr_pkg::*;
   localparam int N = (Stages > 32) ? 32 : Stages;

   q30_type x_ff [N+1];
   q30_type y_ff [N+1];
   logic signed [ZW-1:0] z_ff [N+1];
   logic neg_ff [N+1];
   logic signed [ZW-1:0] z_in;
   logic neg_in;

   always_comb begin
      z_in = ZW'(angle) <<< 17;
      neg_in = 1'b0;
      if (z_in > Q30HalfPi) begin
         z_in = z_in - Q30Pi;
         neg_in = 1'b1;
      end else if (z_in < -Q30HalfPi) begin
         z_in = z_in + Q30Pi;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0] <= Q30Gain;
      y_ff[0] <= '0;
      z_ff[0] <= z_in;
      neg_ff[0] <= neg_in;
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      always_ff @(posedge clock) begin
         neg_ff[i+1] <= neg_ff[i];
         if (!z_ff[i][ZW-1]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - atan_q30(i);
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + atan_q30(i);
         end
      end
   end

   assign cos_q = neg_ff[N] ? -x_ff[N] : x_ff[N];
   assign sin_q = neg_ff[N] ? -y_ff[N] : y_ff[N];
endmodule

// ----- hw/rtl/euler_frame_rotation.sv -----
// Top level of the Euler frame rotation block.
// Depends on efr_pkg and efr_cordic.
//
// Usage:
//  - Request beat: req_* fields accepted on a clock edge with start high;
//    busy is tied low, so a beat may come every cycle.
//  - Result beat: rsp_* fields valid for one cycle while done is high.
//    The receiver cannot stall; results leave in request order.
//  - Throughput: one beat per cycle, set by the fully pipelined CORDIC
//    stages and the registered multiplier stages after it.
//  - Pipeline: input register, CORDIC stages (three in parallel), first
//    products, matrix elements, vector products, row sums, rounding and
//    saturation into the output register.
//  - Reset clears the valid bits only; items in flight are dropped.
module euler_frame_rotation #(
   parameter int CORDIC_STAGES = efr_pkg::CordicStagesDef
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_func,
   input  logic signed [efr_pkg::AngW-1:0]   req_roll_angle,
   input  logic signed [efr_pkg::AngW-1:0]   req_pitch_angle,
   input  logic signed [efr_pkg::AngW-1:0]   req_yaw_angle,
   input  logic signed [efr_pkg::VecW-1:0]   req_vec_x,
   input  logic signed [efr_pkg::VecW-1:0]   req_vec_y,
   input  logic signed [efr_pkg::VecW-1:0]   req_vec_z,
   output logic                              done,
   output logic signed [efr_pkg::VecW-1:0]   rsp_out_x,
   output logic signed [efr_pkg::VecW-1:0]   rsp_out_y,
   output logic signed [efr_pkg::VecW-1:0]   rsp_out_z,
   output logic                              rsp_saturated
);
   import efr_pkg::*;
   localparam int N = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
   // delay from angle register to sin/cos out of the CORDIC
   localparam int CD = N + 1;
   localparam int Lat = CD + 6;

   assign busy = 1'b0;

   logic signed [AngW-1:0] roll_ff, pitch_ff, yaw_ff;
   logic [Lat-1:0] vld_ff;
   logic [CD+1:0] fn_ff;
   logic signed [VecW-1:0] vx_ff [CD+3];
   logic signed [VecW-1:0] vy_ff [CD+3];
   logic signed [VecW-1:0] vz_ff [CD+3];

   always_ff @(posedge clock) begin
      roll_ff <= req_roll_angle;
      pitch_ff <= req_pitch_angle;
      yaw_ff <= req_yaw_angle;
      fn_ff <= {fn_ff[CD:0], req_func};
      vx_ff[0] <= req_vec_x;
      vy_ff[0] <= req_vec_y;
      vz_ff[0] <= req_vec_z;
      for (int i = 1; i < CD + 3; i++) begin
         vx_ff[i] <= vx_ff[i-1];
         vy_ff[i] <= vy_ff[i-1];
         vz_ff[i] <= vz_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[Lat-2:0], start};
      end
   end

   q30_type sr, cr, st, ct, sp, cp;
   efr_cordic #(.Stages(CORDIC_STAGES)) u_roll (
      .clock(clock), .angle(roll_ff), .sin_q(sr), .cos_q(cr));
   efr_cordic #(.Stages(CORDIC_STAGES)) u_pitch (
      .clock(clock), .angle(pitch_ff), .sin_q(st), .cos_q(ct));
   efr_cordic #(.Stages(CORDIC_STAGES)) u_yaw (
      .clock(clock), .angle(yaw_ff), .sin_q(sp), .cos_q(cp));

   // stage A: pairwise products
   q30_type srst_ff, crst_ff, crsp_ff, srsp_ff, crcp_ff, srcp_ff;
   q30_type ctcp_ff, ctsp_ff, srct_ff, crct_ff, nst_ff, sp_a_ff, cp_a_ff;
   always_ff @(posedge clock) begin
      srst_ff <= mul30(sr, st);
      crst_ff <= mul30(cr, st);
      crsp_ff <= mul30(cr, sp);
      srsp_ff <= mul30(sr, sp);
      crcp_ff <= mul30(cr, cp);
      srcp_ff <= mul30(sr, cp);
      ctcp_ff <= mul30(ct, cp);
      ctsp_ff <= mul30(ct, sp);
      srct_ff <= mul30(sr, ct);
      crct_ff <= mul30(cr, ct);
      nst_ff <= -st;
      sp_a_ff <= sp;
      cp_a_ff <= cp;
   end

   // stage B: matrix elements, transposed as required
   q30_type m_ff [3][3];
   q30_type m_in [3][3];
   always_comb begin
      q30_type r [3][3];
      r[0][0] = ctcp_ff;
      r[0][1] = mul30(srst_ff, cp_a_ff) - crsp_ff;
      r[0][2] = mul30(crst_ff, cp_a_ff) + srsp_ff;
      r[1][0] = ctsp_ff;
      r[1][1] = mul30(srst_ff, sp_a_ff) + crcp_ff;
      r[1][2] = mul30(crst_ff, sp_a_ff) - srcp_ff;
      r[2][0] = nst_ff;
      r[2][1] = srct_ff;
      r[2][2] = crct_ff;
      for (int a = 0; a < 3; a++)
         for (int b = 0; b < 3; b++)
            m_in[a][b] = fn_ff[CD+1] ? r[b][a] : r[a][b];
   end
   always_ff @(posedge clock) m_ff <= m_in;

   // stage C: nine products (Q46, halved)
   localparam int PW = QW + VecW;
   logic signed [PW-1:0] p_ff [3][3];
   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         p_ff[a][0] <= (PW'(m_ff[a][0]) * PW'(vx_ff[CD+2])) >>> 1;
         p_ff[a][1] <= (PW'(m_ff[a][1]) * PW'(vy_ff[CD+2])) >>> 1;
         p_ff[a][2] <= (PW'(m_ff[a][2]) * PW'(vz_ff[CD+2])) >>> 1;
      end
   end

   // stage D: row sums
   localparam int SW = PW + 2;
   logic signed [SW-1:0] s_ff [3];
   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++)
         s_ff[a] <= SW'(p_ff[a][0]) + SW'(p_ff[a][1]) + SW'(p_ff[a][2]);
   end

   // stage E: rounding and saturation
   logic signed [VecW-1:0] o_in [3];
   logic [2:0] sat_in;
   always_comb begin
      logic signed [SW-1:0] t;
      for (int a = 0; a < 3; a++) begin
         t = (s_ff[a] + (SW'(1) <<< 28)) >>> 29;
         sat_in[a] = 1'b0;
         o_in[a] = VecW'(t);
         if (t > SW'(32'sh7fffffff)) begin
            o_in[a] = 32'sh7fffffff;
            sat_in[a] = 1'b1;
         end else if (t < -(SW'(1) <<< 31)) begin
            o_in[a] = 32'sh80000000;
            sat_in[a] = 1'b1;
         end
      end
   end
   always_ff @(posedge clock) begin
      rsp_out_x <= o_in[0];
      rsp_out_y <= o_in[1];
      rsp_out_z <= o_in[2];
      rsp_saturated <= |sat_in;
   end

   assign done = vld_ff[Lat-1];
endmodule

// ----- hw/rtl/efr_checker.sv -----
// Port-level checker for euler_frame_rotation, bound to the top level.
// Depends on efr_pkg.
module efr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            done,
   input logic signed [efr_pkg::VecW-1:0] rsp_out_x,
   input logic signed [efr_pkg::VecW-1:0] rsp_out_y,
   input logic signed [efr_pkg::VecW-1:0] rsp_out_z,
   input logic                            rsp_saturated
);
   import efr_pkg::*;
   a_never_busy: assert property (@(posedge clock) !busy) else $error("busy raised");
   a_reset_quiet: assert property (@(posedge clock) reset |=> !done)
      else $error("done after reset");
   a_done_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(done))
      else $error("done unknown");
   a_sat_clip: assert property (@(posedge clock) disable iff (reset)
      (done && rsp_saturated) |-> (rsp_out_x == 32'sh7fffffff ||
         rsp_out_x == 32'sh80000000 || rsp_out_y == 32'sh7fffffff ||
         rsp_out_y == 32'sh80000000 || rsp_out_z == 32'sh7fffffff ||
         rsp_out_z == 32'sh80000000))
      else $error("saturated without clipped value");
endmodule

bind euler_frame_rotation efr_checker u_efr_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .done(done),
   .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z),
   .rsp_saturated(rsp_saturated));
